// ----- rtl/core/cvt_pkg.sv -----
// Shared types, register codes and constants for the cone visibility tracker.
package cvt_pkg;

	localparam int SLOT_W = 12;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SHOWN  = 2'd1;
	localparam logic [1:0] EV_HIDDEN = 2'd2;

	localparam logic [2:0] REG_LX   = 3'd0;
	localparam logic [2:0] REG_LY   = 3'd1;
	localparam logic [2:0] REG_LZ   = 3'd2;
	localparam logic [2:0] REG_DIR  = 3'd3;
	localparam logic [2:0] REG_RAD  = 3'd4;
	localparam logic [2:0] REG_KEEP = 3'd5;
	localparam logic [2:0] REG_COS  = 3'd6;
	localparam logic [2:0] REG_OUTF = 3'd7;

	localparam logic [47:0] DIR_RESET  = 48'hC000_0000_0000;
	localparam logic [23:0] RAD_RESET  = 24'd8192;
	localparam logic [23:0] KEEP_RESET = 24'd1280;
	localparam logic [15:0] COS_RESET  = 16'd25736;
	localparam logic [14:0] OUTF_RESET = 15'd8192;

	typedef struct packed {
		logic                    command;
		logic [SLOT_W-1:0]       object_slot;
		logic                    realized;
		logic signed [31:0]      obj_x;
		logic signed [31:0]      obj_y;
		logic signed [31:0]      obj_z;
	} item_t;

	typedef struct packed {
		logic [1:0]        event_res;
		logic [SLOT_W-1:0] event_slot;
	} result_t;

	typedef struct packed {
		logic signed [31:0] listener_x;
		logic signed [31:0] listener_y;
		logic signed [31:0] listener_z;
		logic [47:0]        view_direction;
		logic [23:0]        show_radius;
		logic [23:0]        keep_margin;
		logic signed [15:0] cone_limit;
		logic [14:0]        outside_factor;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLEAR,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_DOT,
		OP_DIV1_INIT,
		OP_DIV,
		OP_CONE,
		OP_DIV2_INIT,
		OP_FMUL,
		OP_FACT,
		OP_CMP1,
		OP_CMP2,
		OP_DECIDE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic clear_cmd;
		logic in_range;
		logic realized;
		logic dist_zero;
		logic cone_full;
	} dp_status_t;

endpackage

// ----- rtl/core/cone_visibility_tracker_top.sv -----
// Top level of the cone visibility tracker: configuration registers and core wiring.
// A test of an unrealized or out-of-range object goes from the route state straight to the decide and done states.
// A full test runs the 32-step square root and up to two 15-step divides.
// One item is in work at a time; the next is taken once the result is registered.
// A clear command sweeps the visible set one slot a cycle.
// After reset the same sweep runs over every slot before the first item is taken.
module cone_visibility_tracker_top #(
	parameter int OBJECT_SLOTS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  cvt_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output cvt_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [5:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import cvt_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.listener_x     <= '0;
			cfg_q.listener_y     <= '0;
			cfg_q.listener_z     <= '0;
			cfg_q.view_direction <= DIR_RESET;
			cfg_q.show_radius    <= RAD_RESET;
			cfg_q.keep_margin    <= KEEP_RESET;
			cfg_q.cone_limit     <= COS_RESET;
			cfg_q.outside_factor <= OUTF_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[5:3])
				REG_LX:   cfg_q.listener_x     <= pwdata[31:0];
				REG_LY:   cfg_q.listener_y     <= pwdata[31:0];
				REG_LZ:   cfg_q.listener_z     <= pwdata[31:0];
				REG_DIR:  cfg_q.view_direction <= pwdata[47:0];
				REG_RAD:  cfg_q.show_radius    <= pwdata[23:0];
				REG_KEEP: cfg_q.keep_margin    <= pwdata[23:0];
				REG_COS:  cfg_q.cone_limit     <= pwdata[15:0];
				REG_OUTF: cfg_q.outside_factor <= pwdata[14:0];
				default:  cfg_q.listener_x     <= cfg_q.listener_x;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_LX:   prdata = {32'b0, cfg_q.listener_x};
			REG_LY:   prdata = {32'b0, cfg_q.listener_y};
			REG_LZ:   prdata = {32'b0, cfg_q.listener_z};
			REG_DIR:  prdata = {16'b0, cfg_q.view_direction};
			REG_RAD:  prdata = {40'b0, cfg_q.show_radius};
			REG_KEEP: prdata = {40'b0, cfg_q.keep_margin};
			REG_COS:  prdata = {48'b0, cfg_q.cone_limit};
			REG_OUTF: prdata = {49'b0, cfg_q.outside_factor};
			default:  prdata = '0;
		endcase
	end

	cvt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	cvt_datapath #(
		.OBJECT_SLOTS (OBJECT_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.cfg    (cfg_q),
		.status (status),
		.result (result)
	);

endmodule

// ----- rtl/core/cvt_datapath.sv -----
// Datapath: offsets, shared multiplier, square root, divider, visible set memory.
module cvt_datapath #(
	parameter int OBJECT_SLOTS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cvt_pkg::dp_cmd_t  cmd,
	input  cvt_pkg::item_t    item,
	input  cvt_pkg::cfg_t     cfg,
	output cvt_pkg::dp_status_t status,
	output cvt_pkg::result_t  result
);
	import cvt_pkg::*;

	localparam int AW = $clog2(OBJECT_SLOTS);
	localparam int XW = AW + SLOT_W;

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] diff;
		diff = 33'(a) - 33'(b);
		if (diff > 33'sd2147483647) return 32'sh7FFF_FFFF;
		else if (diff < -33'sd2147483647) return -32'sd2147483647;
		else return diff[31:0];
	endfunction

	item_t              item_q;
	logic signed [31:0] d_q [3];
	logic               in_range_q;
	logic               seen_q;
	logic [AW-1:0]      swp_q;
	logic               vis_mem_q [OBJECT_SLOTS];

	logic signed [63:0] prod_q;
	logic [63:0]        acc_q;
	logic [63:0]        n_q;
	logic [34:0]        srem_q;
	logic [31:0]        dist_q;
	logic signed [49:0] num_q;
	logic               neg_q;
	logic               ovf_q;
	logic [47:0]        rem_q;
	logic [46:0]        dvs_q;
	logic [14:0]        quo_q;
	logic signed [16:0] dot_q;
	logic               cone_q;
	logic [15:0]        f_q;
	logic [45:0]        lhs_q;
	logic               show_q;
	result_t            pend_q;
	result_t            result_q;

	logic [XW-1:0]      in_slot_w;
	logic [XW-1:0]      it_slot_w;
	logic [AW-1:0]      in_idx;
	logic [AW-1:0]      it_idx;
	logic signed [31:0] d_sel;
	logic signed [15:0] dir_sel;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [34:0]        srem_sh;
	logic [34:0]        trial;
	logic signed [49:0] num_f;
	logic [49:0]        mag_f;
	logic [14:0]        mag_c;
	logic signed [16:0] dot_c;
	logic               cone_full_c;
	logic signed [16:0] dp1;
	logic signed [16:0] cs;
	logic               hide;
	logic               dec_wr;
	logic               dec_bit;
	result_t            dec_res;

	assign in_slot_w = XW'(item.object_slot);
	assign it_slot_w = XW'(item_q.object_slot);
	assign in_idx    = in_slot_w[AW-1:0];
	assign it_idx    = it_slot_w[AW-1:0];

	always_comb begin
		unique case (cmd.axis)
			2'd1: begin
				d_sel   = d_q[1];
				dir_sel = cfg.view_direction[31:16];
			end
			2'd2: begin
				d_sel   = d_q[2];
				dir_sel = cfg.view_direction[47:32];
			end
			default: begin
				d_sel   = d_q[0];
				dir_sel = cfg.view_direction[15:0];
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQ: begin
				mul_a = d_sel;
				mul_b = d_sel;
			end
			OP_DOT: begin
				mul_a = d_sel;
				mul_b = 32'(dir_sel);
			end
			OP_FMUL: begin
				mul_a = {17'b0, 15'(15'd16384 - quo_q)};
				mul_b = {17'b0, cfg.outside_factor};
			end
			OP_CMP1: begin
				mul_a = {16'b0, f_q};
				mul_b = {8'b0, cfg.show_radius};
			end
			OP_CMP2: begin
				mul_a = {16'b0, f_q};
				mul_b = {7'b0, 25'(cfg.show_radius) + 25'(cfg.keep_margin)};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign srem_sh = {srem_q[32:0], n_q[63:62]};
	assign trial   = {1'b0, dist_q, 2'b01};
	assign num_f   = num_q + $signed(prod_q[49:0]);
	assign mag_f   = num_f[49] ? 50'(-num_f) : 50'(num_f);
	assign mag_c   = (ovf_q || quo_q > 15'd16384) ? 15'd16384 : quo_q;
	assign dot_c   = (dist_q == '0) ? 17'sd0 :
		(neg_q ? -$signed({2'b00, mag_c}) : $signed({2'b00, mag_c}));
	assign cone_full_c = dot_c >= 17'(cfg.cone_limit);
	assign dp1 = dot_q + 17'sd16384;
	assign cs  = 17'(cfg.cone_limit) + 17'sd16384;
	assign hide = 64'(lhs_q) > $unsigned(prod_q);

	always_comb begin
		dec_wr  = 1'b0;
		dec_bit = 1'b0;
		dec_res.event_res  = EV_NONE;
		dec_res.event_slot = item_q.object_slot;
		if (item_q.command) begin
			dec_res.event_slot = '0;
		end else if (in_range_q) begin
			if (!item_q.realized || seen_q) begin
				if (seen_q && (!item_q.realized || hide)) begin
					dec_res.event_res = EV_HIDDEN;
					dec_wr = 1'b1;
				end
			end else if (show_q) begin
				dec_res.event_res = EV_SHOWN;
				dec_wr  = 1'b1;
				dec_bit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLEAR) begin
			vis_mem_q[swp_q] <= 1'b0;
		end else if (cmd.op == OP_DECIDE && dec_wr) begin
			vis_mem_q[it_idx] <= dec_bit;
		end
		if (cmd.op == OP_LOAD) begin
			seen_q <= vis_mem_q[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			if (swp_q == AW'(OBJECT_SLOTS - 1)) swp_q <= '0;
			else swp_q <= swp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				item_q     <= item;
				in_range_q <= in_slot_w < XW'(OBJECT_SLOTS);
				d_q[0]     <= sat_sub(item.obj_x, cfg.listener_x);
				d_q[1]     <= sat_sub(item.obj_y, cfg.listener_y);
				d_q[2]     <= sat_sub(item.obj_z, cfg.listener_z);
			end
			OP_SQ: begin
				prod_q <= mul_a * mul_b;
				acc_q  <= (cmd.axis == 2'd0) ? 64'd0 : acc_q + $unsigned(prod_q);
			end
			OP_SQRT_INIT: begin
				n_q    <= acc_q + $unsigned(prod_q);
				dist_q <= '0;
				srem_q <= '0;
			end
			OP_SQRT: begin
				n_q <= {n_q[61:0], 2'b00};
				if (srem_sh >= trial) begin
					srem_q <= srem_sh - trial;
					dist_q <= {dist_q[30:0], 1'b1};
				end else begin
					srem_q <= srem_sh;
					dist_q <= {dist_q[30:0], 1'b0};
				end
			end
			OP_DOT: begin
				prod_q <= mul_a * mul_b;
				num_q  <= (cmd.axis == 2'd0) ? 50'sd0 : num_f;
			end
			OP_DIV1_INIT: begin
				neg_q <= num_f[49];
				rem_q <= mag_f[47:0];
				dvs_q <= {1'b0, dist_q, 14'b0};
				ovf_q <= mag_f[47:0] >= {1'b0, dist_q, 15'b0};
				quo_q <= '0;
			end
			OP_DIV: begin
				dvs_q <= {1'b0, dvs_q[46:1]};
				if (rem_q >= 48'(dvs_q)) begin
					rem_q <= rem_q - 48'(dvs_q);
					quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					quo_q <= {quo_q[13:0], 1'b0};
				end
			end
			OP_CONE: begin
				dot_q  <= dot_c;
				cone_q <= cone_full_c;
			end
			OP_DIV2_INIT: begin
				rem_q <= 48'({dp1, 14'b0});
				dvs_q <= 47'({cs[15:0], 14'b0});
				quo_q <= '0;
			end
			OP_FMUL: begin
				prod_q <= mul_a * mul_b;
			end
			OP_FACT: begin
				f_q <= cone_q ? 16'd16384 : 16'(quo_q) + prod_q[29:14];
			end
			OP_CMP1: begin
				prod_q <= mul_a * mul_b;
				lhs_q  <= {dist_q, 14'b0};
			end
			OP_CMP2: begin
				prod_q <= mul_a * mul_b;
				show_q <= 64'(lhs_q) <= $unsigned(prod_q);
			end
			OP_DECIDE: begin
				pend_q <= dec_res;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			result_q <= pend_q;
		end
	end

	assign result = result_q;

	assign status.sweep_last = swp_q == AW'(OBJECT_SLOTS - 1);
	assign status.clear_cmd  = item_q.command;
	assign status.in_range   = in_range_q;
	assign status.realized   = item_q.realized;
	assign status.dist_zero  = dist_q == '0;
	assign status.cone_full  = cone_full_c;

endmodule

// ----- rtl/core/cvt_ctrl.sv -----
// Controller state machine that sequences the datapath and the result transfer.
module cvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  cvt_pkg::dp_status_t status,
	output cvt_pkg::dp_cmd_t    cmd
);
	import cvt_pkg::*;

	typedef enum logic [4:0] {
		S_SWEEP,
		S_IDLE,
		S_ROUTE,
		S_SQ,
		S_SQRT_INIT,
		S_SQRT,
		S_DOT,
		S_DIV1_INIT,
		S_DIV,
		S_CONE,
		S_DIV2_INIT,
		S_FMUL,
		S_FACT,
		S_CMP1,
		S_CMP2,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       second_q;
	logic       boot_q;
	logic       result_valid_q;
	logic       load_out;

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign load_out     = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		cmd.axis     = cnt_q[1:0];
		cmd.load_out = load_out;
		unique case (state_q)
			S_SWEEP:     cmd.op = OP_CLEAR;
			S_IDLE:      cmd.op = item_valid ? OP_LOAD : OP_NOP;
			S_SQ:        cmd.op = OP_SQ;
			S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			S_SQRT:      cmd.op = OP_SQRT;
			S_DOT:       cmd.op = OP_DOT;
			S_DIV1_INIT: cmd.op = OP_DIV1_INIT;
			S_DIV:       cmd.op = OP_DIV;
			S_CONE:      cmd.op = OP_CONE;
			S_DIV2_INIT: cmd.op = OP_DIV2_INIT;
			S_FMUL:      cmd.op = OP_FMUL;
			S_FACT:      cmd.op = OP_FACT;
			S_CMP1:      cmd.op = OP_CMP1;
			S_CMP2:      cmd.op = OP_CMP2;
			S_DECIDE:    cmd.op = OP_DECIDE;
			default:     cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_SWEEP;
			cnt_q          <= '0;
			second_q       <= 1'b0;
			boot_q         <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			if (load_out) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;

			unique case (state_q)
				S_SWEEP: begin
					if (status.sweep_last) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_DECIDE;
					end
				end
				S_IDLE: begin
					if (item_valid) state_q <= S_ROUTE;
				end
				S_ROUTE: begin
					cnt_q <= '0;
					if (status.clear_cmd) state_q <= S_SWEEP;
					else if (!status.in_range || !status.realized) state_q <= S_DECIDE;
					else state_q <= S_SQ;
				end
				S_SQ: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= S_SQRT_INIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQRT_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) state_q <= S_DOT;
				end
				S_DOT: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= status.dist_zero ? S_CONE : S_DIV1_INIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV1_INIT: begin
					cnt_q    <= '0;
					second_q <= 1'b0;
					state_q  <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 5'd14) begin
						cnt_q   <= '0;
						state_q <= second_q ? S_FMUL : S_CONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CONE: begin
					state_q <= status.cone_full ? S_FACT : S_DIV2_INIT;
				end
				S_DIV2_INIT: begin
					cnt_q    <= '0;
					second_q <= 1'b1;
					state_q  <= S_DIV;
				end
				S_FMUL:   state_q <= S_FACT;
				S_FACT:   state_q <= S_CMP1;
				S_CMP1:   state_q <= S_CMP2;
				S_CMP2:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_routes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && item_valid) |=> (state_q == S_ROUTE && item_stall))
		else $error("accepted transfer did not enter routing");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

	a_sqrt_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT && cnt_q == 5'd31) |=> (state_q == S_DOT && cnt_q == 5'd0))
		else $error("square root did not end after 32 steps");

endmodule
